// ===== rtl/bp2rgb_pkg.sv =====
// Shared types, constants and the colour packing function for the bitplane
// to RGB555 palette converter. No dependencies.

package bp2rgb_pkg;

   localparam int PLANE_COUNT  = 6;   // planes that may contribute, 1..6
   localparam int INPUT_PLANES = 6;   // plane bytes carried by one item
   localparam int PIXELS       = 8;
   localparam int INDEX_W      = 6;
   localparam int BANK_AW      = 5;   // each palette half holds 32 entries
   localparam int BANK_DEPTH   = 32;
   localparam int ENTRIES      = 64;
   localparam int PIXEL_W      = 16;
   localparam int COLOR_W      = 24;
   localparam int CMD_W        = 2;

   localparam logic [CMD_W-1:0] CMD_RENDER     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_PAIR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE_ONE  = 2'd2;

   typedef logic [INPUT_PLANES-1:0][7:0]  plane_bytes_type;
   typedef logic [PIXELS-1:0][INDEX_W-1:0] pixel_index_type;

   // Palette write towards every lane: the lower and upper halves may be
   // written at the same offset in one cycle (half-brite pair).
   typedef struct packed {
      logic               en_lo;
      logic               en_hi;
      logic [BANK_AW-1:0] addr;
      logic [PIXEL_W-1:0] data_lo;
      logic [PIXEL_W-1:0] data_hi;
   } pal_wr_type;

   // R in bits 0-4, bit 5 zero, G in bits 6-10, B in bits 11-15.
   function automatic logic [PIXEL_W-1:0] pack_rgb555(input logic [7:0] r8,
                                                      input logic [7:0] g8,
                                                      input logic [7:0] b8);
      return {b8[7:3], g8[7:3], 1'b0, r8[7:3]};
   endfunction

endpackage

// ===== rtl/bp2rgb_index_gen.sv =====
// Turns six plane bytes into eight 6-bit palette indices.
// Depends on bp2rgb_pkg.

module bp2rgb_index_gen
   import bp2rgb_pkg::*;
(
   input  plane_bytes_type         planes,
   input  logic [INDEX_W-1:0]      plane_enable,
   output pixel_index_type         pixel_index
);

   // Pixel i takes bit 7-i of each plane; disabled planes and planes at or
   // above the plane count read as zero.
   always_comb begin
      for (int i = 0; i < PIXELS; i++) begin
         for (int k = 0; k < INDEX_W; k++) begin
            if (k < PLANE_COUNT && k < INPUT_PLANES) begin
               pixel_index[i][k] = plane_enable[k] & planes[k][7-i];
            end else begin
               pixel_index[i][k] = 1'b0;
            end
         end
      end
   end

endmodule

// ===== rtl/bp2rgb_lane.sv =====
// One pixel lane's copy of the palette, held as two 32-entry halves so that
// a half-brite pair is written in one cycle. Registered read.
// Depends on bp2rgb_pkg.

module bp2rgb_lane
   import bp2rgb_pkg::*;
(
   input  logic                clock,
   input  pal_wr_type          wr,
   input  logic                rd_en,
   input  logic [INDEX_W-1:0]  rd_index,
   output logic [PIXEL_W-1:0]  rd_data
);

   logic [PIXEL_W-1:0] lo_mem [BANK_DEPTH];
   logic [PIXEL_W-1:0] hi_mem [BANK_DEPTH];
   logic [PIXEL_W-1:0] lo_q_ff;
   logic [PIXEL_W-1:0] hi_q_ff;
   logic               hi_sel_ff;

   always_ff @(posedge clock) begin
      if (wr.en_lo) begin
         lo_mem[wr.addr] <= wr.data_lo;
      end
      if (wr.en_hi) begin
         hi_mem[wr.addr] <= wr.data_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lo_q_ff   <= lo_mem[rd_index[BANK_AW-1:0]];
         hi_q_ff   <= hi_mem[rd_index[BANK_AW-1:0]];
         hi_sel_ff <= rd_index[INDEX_W-1];
      end
   end

   assign rd_data = hi_sel_ff ? hi_q_ff : lo_q_ff;

endmodule

// ===== rtl/bitplane_to_rgb555_palette_top.sv =====
// Top level of the bitplane to RGB555 palette converter: input register,
// palette write decode, entry valid bits and the result register.
// Depends on bp2rgb_pkg, bp2rgb_index_gen and bp2rgb_lane.

// Usage
// The req_ channel carries one item per handshake. req_tuser holds the
// command: render eight pixels, write a palette entry with its half-brite
// partner, or write a single entry. Render items produce one rsp_ item of
// eight RGB555 pixels, leftmost pixel in the lowest 16 bits; palette writes
// and the unused command produce nothing.
// The csr_ channel writes plane_enable; it is always ready and should only
// be written while no item is in flight.
// From req_ acceptance to rsp_tvalid an item passes the input register and then
// the palette read register that doubles as the result register. While the
// receiver does not stall, throughput is one item per cycle, set by the eight lane
// copies of the palette, each read at one address per cycle.
// A palette write takes effect for the very next render item.
// When the receiver stalls, the result is held and the input register
// holds its item; req_tready falls once both are full and rises again in
// the cycle that rsp_tready returns.
// Reset clears plane_enable to all planes on and marks every palette entry
// invalid, so unwritten entries read as black; no clearing pass is needed.

module bitplane_to_rgb555_palette_top
   import bp2rgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [47:0] plane0_byte..plane5_byte, [53:48] entry_index,
   // [77:54] entry_color, [79:78] zero
   input  logic [79:0]  req_tdata,
   // [1:0] cmd
   input  logic [1:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] pixel_0, [31:16] pixel_1, ... [127:112] pixel_7
   output logic [127:0] rsp_tdata,

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [5:0]   csr_data
);

   // Configuration register
   logic [INDEX_W-1:0] plane_enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_enable_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         plane_enable_ff <= csr_data;
      end
   end

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]    s1_cmd_ff;
   plane_bytes_type     s1_planes_ff;
   logic [INDEX_W-1:0]  s1_index_ff;
   logic [COLOR_W-1:0]  s1_color_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;
   logic                req_fire;

   // The result register moves when it is empty or being taken; the input
   // register empties into it (or into the palette) at the same edge.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= req_tuser;
         s1_planes_ff <= req_tdata[47:0];
         s1_index_ff  <= req_tdata[53:48];
         s1_color_ff  <= req_tdata[77:54];
      end
   end

   // Palette write decode
   logic               s1_leaves;
   logic               wr_any;
   logic               wr_pair;
   logic [7:0]         r8, g8, b8;
   logic [PIXEL_W-1:0] full_color;
   logic [PIXEL_W-1:0] half_color;
   pal_wr_type         wr;

   assign s1_leaves = s1_valid_ff && advance;
   assign r8 = s1_color_ff[23:16];
   assign g8 = s1_color_ff[15:8];
   assign b8 = s1_color_ff[7:0];
   assign full_color = pack_rgb555(r8, g8, b8);
   assign half_color = pack_rgb555({1'b0, r8[7:1]}, {1'b0, g8[7:1]}, {1'b0, b8[7:1]});

   always_comb begin
      wr_any  = 1'b0;
      wr_pair = 1'b0;
      unique case (s1_cmd_ff)
         CMD_WRITE_PAIR: begin
            wr_any  = 1'b1;
            wr_pair = !s1_index_ff[INDEX_W-1];
         end
         CMD_WRITE_ONE: begin
            wr_any = 1'b1;
         end
         default: begin
            wr_any = 1'b0;
         end
      endcase
   end

   // A pair write to a lower-half entry puts the colour there and its half-brite
   // copy at the same offset in the upper half; to an upper-half entry it writes only that entry.
   always_comb begin
      wr.en_lo   = s1_leaves && wr_any && !s1_index_ff[INDEX_W-1];
      wr.en_hi   = s1_leaves && wr_any && (s1_index_ff[INDEX_W-1] || wr_pair);
      wr.addr    = s1_index_ff[BANK_AW-1:0];
      wr.data_lo = full_color;
      wr.data_hi = wr_pair ? half_color : full_color;
   end

   // Entry valid bits: an entry never written reads as black.
   logic [ENTRIES-1:0] entry_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         if (wr.en_lo) begin
            entry_valid_ff[{1'b0, wr.addr}] <= 1'b1;
         end
         if (wr.en_hi) begin
            entry_valid_ff[{1'b1, wr.addr}] <= 1'b1;
         end
      end
   end

   // Pixel indices and lane lookups
   pixel_index_type    pixel_index;
   logic [PIXELS-1:0]  pix_valid_ff;
   logic [PIXEL_W-1:0] lane_data [PIXELS];

   bp2rgb_index_gen u_index_gen (
      .planes       (s1_planes_ff),
      .plane_enable (plane_enable_ff),
      .pixel_index  (pixel_index)
   );

   for (genvar g = 0; g < PIXELS; g++) begin : g_lane
      bp2rgb_lane u_lane (
         .clock    (clock),
         .wr       (wr),
         .rd_en    (advance),
         .rd_index (pixel_index[g]),
         .rd_data  (lane_data[g])
      );

      always_ff @(posedge clock) begin
         if (advance) begin
            pix_valid_ff[g] <= entry_valid_ff[pixel_index[g]];
         end
      end

      assign rsp_tdata[g*PIXEL_W +: PIXEL_W] = pix_valid_ff[g] ? lane_data[g] : '0;
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff && (s1_cmd_ff == CMD_RENDER);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_render_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      (s1_leaves && s1_cmd_ff == CMD_RENDER) |=> rsp_tvalid)
      else $error("render item did not reach the result register");

   a_write_no_rsp : assert property (@(posedge clock) disable iff (reset)
      (s1_leaves && s1_cmd_ff != CMD_RENDER) |=> !rsp_tvalid)
      else $error("non-render item produced a result");

   a_blocked_not_ready : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_tready)
      else $error("input accepted while the input register is blocked");

   a_pair_writes_both : assert property (@(posedge clock) disable iff (reset)
      (s1_leaves && s1_cmd_ff == CMD_WRITE_PAIR && !s1_index_ff[INDEX_W-1])
      |-> (wr.en_lo && wr.en_hi))
      else $error("half-brite write did not update both halves");

   a_write_marks_valid : assert property (@(posedge clock) disable iff (reset)
      wr.en_hi |=> entry_valid_ff[{1'b1, $past(wr.addr)}])
      else $error("upper palette entry not marked valid after a write");
`endif

endmodule
